// ===== rtl/core/vsfp_pkg.sv =====
// ----------------------------------------------------------------------------
// vsfp_pkg - shared types and constants for the vital-sign frame parser
// Frame delimiter, command codes, capture offsets and the result record.
// ----------------------------------------------------------------------------
package vsfp_pkg;

    localparam logic [7:0] DELIM    = 8'hFB;
    localparam logic [7:0] CMD_TEMP = 8'h06;
    localparam logic [7:0] CMD_SPO2 = 8'h02;

    // frame lengths count both delimiters
    localparam int MIN_FRAME_LEN      = 5;
    localparam int MIN_TEMP_FRAME_LEN = 10;
    localparam int MIN_SPO2_FRAME_LEN = 7;

    localparam int POS_W = 4;
    localparam logic [POS_W-1:0] POS_MAX   = '1;
    localparam logic [POS_W-1:0] POS_FIRST = POS_W'(1);

    // length >= N  <=>  position of closing byte >= N-1
    localparam logic [POS_W-1:0] POS_MIN_FRAME = POS_W'(MIN_FRAME_LEN - 1);
    localparam logic [POS_W-1:0] POS_MIN_TEMP  = POS_W'(MIN_TEMP_FRAME_LEN - 1);
    localparam logic [POS_W-1:0] POS_MIN_SPO2  = POS_W'(MIN_SPO2_FRAME_LEN - 1);

    // capture offsets
    localparam logic [POS_W-1:0] OFS_CMD = POS_W'(3);
    localparam logic [POS_W-1:0] OFS_5   = POS_W'(5);
    localparam logic [POS_W-1:0] OFS_6   = POS_W'(6);
    localparam logic [POS_W-1:0] OFS_7   = POS_W'(7);
    localparam logic [POS_W-1:0] OFS_8   = POS_W'(8);

    localparam logic KIND_TEMP = 1'b0;
    localparam logic KIND_SPO2 = 1'b1;

    typedef struct packed {
        logic       reading_kind;
        logic [7:0] pulse_rate;
        logic [7:0] spo2_percent;
        logic [7:0] temp_unit;
        logic [7:0] temp_tenths;
        logic [7:0] temp_whole;
    } vsfp_result_t;

endpackage

// ===== rtl/core/vsfp_frame_tracker.sv =====
// ----------------------------------------------------------------------------
// vsfp_frame_tracker - frame state, byte capture and result decode
// Tracks delimiters and position, captures the command and payload bytes,
// and flags a result on the byte that closes a valid frame.
// ----------------------------------------------------------------------------
module vsfp_frame_tracker
    import vsfp_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         byte_fire,
    input  logic [7:0]   rx_byte,
    output logic         res_valid,
    output vsfp_result_t res
);

    logic             inside_reg, inside_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       cmd_reg, cmd_next;
    logic [7:0]       ofs5_reg, ofs5_next;
    logic [7:0]       ofs6_reg, ofs6_next;
    logic [7:0]       ofs7_reg, ofs7_next;
    logic [7:0]       ofs8_reg, ofs8_next;
    logic             closing;

    always_comb begin
        inside_next = inside_reg;
        pos_next    = pos_reg;
        cmd_next    = cmd_reg;
        ofs5_next   = ofs5_reg;
        ofs6_next   = ofs6_reg;
        ofs7_next   = ofs7_reg;
        ofs8_next   = ofs8_reg;
        closing     = 1'b0;
        if (byte_fire) begin
            if (!inside_reg) begin
                if (rx_byte == DELIM) begin
                    inside_next = 1'b1;
                    pos_next    = POS_FIRST;
                end
            end else begin
                // closing delimiter is captured too
                if (pos_reg != POS_MAX) begin
                    unique case (pos_reg)
                        OFS_CMD: cmd_next  = rx_byte;
                        OFS_5:   ofs5_next = rx_byte;
                        OFS_6:   ofs6_next = rx_byte;
                        OFS_7:   ofs7_next = rx_byte;
                        OFS_8:   ofs8_next = rx_byte;
                        default: ;
                    endcase
                end
                if (rx_byte != DELIM) begin
                    if (pos_reg != POS_MAX) begin
                        pos_next = pos_reg + POS_W'(1);
                    end
                end else begin
                    closing     = 1'b1;
                    inside_next = 1'b0;
                    pos_next    = '0;
                end
            end
        end
    end

    always_comb begin
        res       = '0;
        res_valid = 1'b0;
        if (closing && pos_reg >= POS_MIN_FRAME) begin
            if (cmd_next == CMD_TEMP && pos_reg >= POS_MIN_TEMP) begin
                res_valid         = 1'b1;
                res.reading_kind  = KIND_TEMP;
                res.temp_whole    = ofs6_next;
                res.temp_tenths   = ofs7_next;
                res.temp_unit     = ofs8_next;
            end else if (cmd_next == CMD_SPO2 && pos_reg >= POS_MIN_SPO2) begin
                res_valid         = 1'b1;
                res.reading_kind  = KIND_SPO2;
                res.spo2_percent  = ofs5_next;
                res.pulse_rate    = ofs6_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inside_reg <= 1'b0;
            pos_reg    <= '0;
            cmd_reg    <= '0;
            ofs5_reg   <= '0;
            ofs6_reg   <= '0;
            ofs7_reg   <= '0;
            ofs8_reg   <= '0;
        end else begin
            inside_reg <= inside_next;
            pos_reg    <= pos_next;
            cmd_reg    <= cmd_next;
            ofs5_reg   <= ofs5_next;
            ofs6_reg   <= ofs6_next;
            ofs7_reg   <= ofs7_next;
            ofs8_reg   <= ofs8_next;
        end
    end

endmodule

// ===== rtl/core/vsfp_out_buf.sv =====
// ----------------------------------------------------------------------------
// vsfp_out_buf - result register with skid stage
// Holds results for the master side; upstream ready is registered.
// ----------------------------------------------------------------------------
module vsfp_out_buf
    import vsfp_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  vsfp_result_t push_data,
    output logic         can_accept,
    output logic         out_valid,
    input  logic         out_ready,
    output vsfp_result_t out_data
);

    logic         out_valid_reg, out_valid_next;
    logic         skid_valid_reg, skid_valid_next;
    vsfp_result_t out_reg, out_next;
    vsfp_result_t skid_reg, skid_next;

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (!out_valid_reg || out_ready) begin
            if (skid_valid_reg) begin
                // upstream is held off while the skid is full
                out_valid_next  = 1'b1;
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = push;
                out_next       = push_data;
            end
        end else if (push) begin
            skid_valid_next = 1'b1;
            skid_next       = push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign can_accept = !skid_valid_reg;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_reg;

endmodule

// ===== rtl/core/vital_sign_frame_parser_top.sv =====
// ----------------------------------------------------------------------------
// vital_sign_frame_parser_top - vital-sign serial frame parser
// Channel  Dir  Signals                         Content
// s_       in   s_tvalid s_tready s_tdata[7:0]  one received byte
// m_       out  m_tvalid m_tready m_tdata[39:0] temperature or SpO2 reading
//                              m_tuser[0]       reading kind
// One byte is taken per cycle while s_tready is high. A reading is registered
// into the result register, or into the skid stage while m_ stalls. s_tready
// is registered and drops only when both registers hold unread readings.
// Reset (aresetn low, synchronous) leaves the parser outside a frame.
// ----------------------------------------------------------------------------
module vital_sign_frame_parser_top
    import vsfp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [7:0] temp_whole, [15:8] temp_tenths,
                                   // [23:16] temp_unit, [31:24] spo2_percent,
                                   // [39:32] pulse_rate
    output logic        m_tuser    // [0] reading_kind
);

    logic         byte_fire;
    logic         res_valid;
    vsfp_result_t res;
    vsfp_result_t out_data;

    assign byte_fire = s_tvalid && s_tready;

    vsfp_frame_tracker u_tracker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .byte_fire (byte_fire),
        .rx_byte   (s_tdata),
        .res_valid (res_valid),
        .res       (res)
    );

    vsfp_out_buf u_out_buf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (res_valid),
        .push_data  (res),
        .can_accept (s_tready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (out_data)
    );

    assign m_tdata = {out_data.pulse_rate, out_data.spo2_percent, out_data.temp_unit,
                      out_data.temp_tenths, out_data.temp_whole};
    assign m_tuser = out_data.reading_kind;

    // ready only drops with a reading already waiting
    a_ready_low_has_output: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("s_tready low with no pending reading");

    // a new reading always follows an accepted byte
    a_rise_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready))
        else $error("reading appeared without an accepted byte");

    a_spo2_temp_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == KIND_SPO2) |-> (m_tdata[23:0] == 24'h0))
        else $error("SpO2 reading carries temperature bytes");

    a_temp_spo2_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == KIND_TEMP) |-> (m_tdata[39:24] == 16'h0))
        else $error("temperature reading carries SpO2 bytes");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb - regression for vital_sign_frame_parser_top
// Feeds the parser a serial byte stream of framed and unframed bytes. The
// stream holds minimum-length and long frames, short and empty frames, and
// frames that carry other commands. A behavioral parser in the bench predicts
// every reading, and each reading taken from m_ is compared field by field.
// Both sides of the link idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
    import vsfp_pkg::*;

    localparam int CLK_PERIOD     = 12;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 16;
    localparam int RANDOM_ITEMS   = 1150;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tuser;

    vital_sign_frame_parser_top i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // bench copy of the parser state
    logic             in_frame = 1'b0;
    logic [POS_W-1:0] next_pos = '0;
    logic [7:0]       cap_cmd = '0;
    logic [7:0]       cap_ofs5 = '0;
    logic [7:0]       cap_ofs6 = '0;
    logic [7:0]       cap_ofs7 = '0;
    logic [7:0]       cap_ofs8 = '0;

    vsfp_result_t readings_due[$];

    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;
    int unsigned bytes_sent = 0;
    int unsigned frames_sent = 0;
    int unsigned long_frames = 0;
    int unsigned temp_readings = 0;
    int unsigned spo2_readings = 0;
    int unsigned mismatch_count = 0;
    int unsigned quiet_cycles = 0;

    // Advance the bench parser by one byte; queue the reading it yields.
    task automatic parse_byte(input logic [7:0] b);
        vsfp_result_t rd;
        logic [4:0]   frame_len;
        if (!in_frame) begin
            if (b == DELIM) begin
                in_frame = 1'b1;
                next_pos = POS_FIRST;
            end
            return;
        end
        if (next_pos != POS_MAX) begin
            case (next_pos)
                OFS_CMD: cap_cmd  = b;
                OFS_5:   cap_ofs5 = b;
                OFS_6:   cap_ofs6 = b;
                OFS_7:   cap_ofs7 = b;
                OFS_8:   cap_ofs8 = b;
                default: ;
            endcase
        end
        if (b != DELIM) begin
            if (next_pos != POS_MAX) next_pos = next_pos + POS_W'(1);
            return;
        end
        // closing delimiter; saturated position stands for any longer frame
        frame_len = {1'b0, next_pos} + 5'd1;
        in_frame  = 1'b0;
        next_pos  = '0;
        if (frame_len < MIN_FRAME_LEN) return;
        rd = '0;
        if (cap_cmd == CMD_TEMP && frame_len >= MIN_TEMP_FRAME_LEN) begin
            rd.reading_kind = KIND_TEMP;
            rd.temp_whole   = cap_ofs6;
            rd.temp_tenths  = cap_ofs7;
            rd.temp_unit    = cap_ofs8;
            readings_due.push_back(rd);
            temp_readings++;
        end else if (cap_cmd == CMD_SPO2 && frame_len >= MIN_SPO2_FRAME_LEN) begin
            rd.reading_kind = KIND_SPO2;
            rd.spo2_percent = cap_ofs5;
            rd.pulse_rate   = cap_ofs6;
            readings_due.push_back(rd);
            spo2_readings++;
        end
    endtask

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        parse_byte(b);
        bytes_sent++;
    endtask

    // hold the sender off until every pending reading has been taken
    task automatic wait_drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (readings_due.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [7:0] rand_payload();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == DELIM);
        return b;
    endfunction

    // Frame of len bytes, delimiters included; cmd lands at offset 3.
    // With stray set, payload bytes may hit the delimiter and cut the frame.
    task automatic send_frame(input logic [7:0] cmd, input int len, input bit stray);
        send_byte(DELIM);
        for (int p = 1; p <= len - 2; p++) begin
            if (p == OFS_CMD) send_byte(cmd);
            else if (stray) send_byte(8'($urandom_range(0, 255)));
            else send_byte(rand_payload());
        end
        send_byte(DELIM);
        frames_sent++;
        if (len > 16) long_frames++;
    endtask

    // receiver stalls
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("%0t: %s mismatch: expected %02h, got %02h", $realtime, name,
                         want, got);
        end
    endtask

    always @(posedge aclk) begin
        vsfp_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (readings_due.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: unexpected reading kind=%0b data=%010h", $realtime,
                             m_tuser, m_tdata);
            end else begin
                want = readings_due.pop_front();
                check_field("reading_kind", {7'd0, want.reading_kind}, {7'd0, m_tuser});
                check_field("temp_whole", want.temp_whole, m_tdata[7:0]);
                check_field("temp_tenths", want.temp_tenths, m_tdata[15:8]);
                check_field("temp_unit", want.temp_unit, m_tdata[23:16]);
                check_field("spo2_percent", want.spo2_percent, m_tdata[31:24]);
                check_field("pulse_rate", want.pulse_rate, m_tdata[39:32]);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("watchdog: no request moved for %0d cycles", WATCHDOG_LIMIT);
                $display("vital_sign_frame_parser_top regression: fail");
                $finish;
            end
        end
    end

    // minimum temperature frame, payload at both byte extremes
    task automatic test_temp_reading();
        send_byte(DELIM);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(CMD_TEMP);
        send_byte(8'h00);
        send_byte(8'h11);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(DELIM);
    endtask

    // 7-byte SpO2 frame: closing delimiter is captured as pulse rate
    task automatic test_spo2_closing_capture();
        send_byte(DELIM);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(CMD_SPO2);
        send_byte(8'hFF);
        send_byte(8'h5A);
        send_byte(DELIM);
    endtask

    // empty frame, then a 6-byte SpO2 frame that must yield nothing
    task automatic test_short_frames();
        send_byte(DELIM);
        send_byte(DELIM);
        send_byte(DELIM);
        send_byte(8'h01);
        send_byte(8'h02);
        send_byte(CMD_SPO2);
        send_byte(8'h03);
        send_byte(DELIM);
    endtask

    task automatic test_random_traffic(input int unsigned tx_pct, input int unsigned rx_pct,
                                       input int unsigned n_items);
        int unsigned target;
        int unsigned pick;
        int          len;
        logic [7:0]  cmd;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        wait_drain();
        target = bytes_sent + n_items;
        while (bytes_sent < target) begin
            // line noise between frames is dropped
            repeat ($urandom_range(0, 2)) send_byte(rand_payload());
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 22)
                                                  : $urandom_range(9, 12);
                send_frame(CMD_TEMP, len, 1'b0);
            end else if (pick < 70) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 20)
                                                  : $urandom_range(5, 9);
                send_frame(CMD_SPO2, len, 1'b0);
            end else if (pick < 80) begin
                do cmd = 8'($urandom_range(0, 255));
                while (cmd == CMD_TEMP || cmd == CMD_SPO2);
                send_frame(cmd, $urandom_range(5, 12), 1'b0);
            end else begin
                send_frame(8'($urandom_range(0, 255)), $urandom_range(2, 12), 1'b1);
            end
            if ($urandom_range(0, 49) == 0) wait_drain();
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        tx_idle_pct = 24;
        rx_idle_pct = 67;
        test_temp_reading();
        test_spo2_closing_capture();
        test_short_frames();

        test_random_traffic(24, 67, RANDOM_ITEMS / 3);
        test_random_traffic(67, 24, RANDOM_ITEMS / 3);
        test_random_traffic(0, 0, RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));

        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (readings_due.size() != 0) mismatch_count++;

        $display("covered %0d bytes in %0d frames (%0d past saturation)", bytes_sent,
                 frames_sent, long_frames);
        $display("checked %0d temperature and %0d SpO2 readings, %0d mismatches",
                 temp_readings, spo2_readings, mismatch_count);
        if (mismatch_count == 0) begin
            $display("vital_sign_frame_parser_top regression: pass");
        end else begin
            $display("vital_sign_frame_parser_top regression: fail");
        end
        $finish;
    end

endmodule
